### rtl/jddm_pkg.sv
// Shared types and constants for the joystick differential drive mixer.
`default_nettype none

package jddm_pkg;

  localparam int NUM_STAGES = 5;

  typedef logic [9:0]        axis_t;   // raw joystick count
  typedef logic [8:0]        band_t;   // dead band half width
  typedef logic signed [7:0] joy_t;    // mapped axis, -128..127
  typedef logic signed [8:0] premix_t; // drive premix, -1..127
  typedef logic signed [13:0] term_t;  // w*JY and (32-w)*JX
  typedef logic signed [9:0] mix_t;    // per-motor mix
  typedef logic [7:0]        duty_t;

  // Per-stage load enables
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_IDX_DEAD_BAND = 2'd0;
  localparam cfg_idx_t CFG_IDX_CENTER    = 2'd1;

  localparam band_t DEAD_BAND_RST = 9'd30;
  localparam axis_t CENTER_RST    = 10'd511;

endpackage

`default_nettype wire

### rtl/jddm_axis.sv
// Axis conditioning: dead band clamp, then v*255/1023 - 128 over two stages.
`default_nettype none

module jddm_axis
  import jddm_pkg::*;
(
  input  wire logic      clk,
  input  var  stage_en_t en,
  input  wire band_t     dead_band,
  input  wire axis_t     center_value,
  input  wire axis_t     raw,
  output joy_t           joy
);

  logic [10:0] lo_sum;
  logic [10:0] hi_lim;
  logic        in_band;
  axis_t       v_nxt;
  axis_t       v_r;

  logic [17:0] prod;
  logic [7:0]  q0;
  logic [10:0] rem;
  logic [7:0]  quo;
  joy_t        joy_nxt;
  joy_t        joy_r;

  // v >= c - t  <=>  v + t >= c ; v <= c + t
  assign lo_sum  = {1'b0, raw} + {2'b00, dead_band};
  assign hi_lim  = {1'b0, center_value} + {2'b00, dead_band};
  assign in_band = (lo_sum >= {1'b0, center_value}) && ({1'b0, raw} <= hi_lim);
  assign v_nxt   = in_band ? center_value : raw;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      v_r <= v_nxt;
    end
  end

  // n/1023: q0 = n>>10 never overshoots, remainder stays below 2*1023
  assign prod    = {v_r, 8'd0} - {8'd0, v_r};
  assign q0      = prod[17:10];
  assign rem     = {1'b0, prod[9:0]} + {3'd0, q0};
  assign quo     = q0 + {7'd0, (rem >= 11'd1023)};
  assign joy_nxt = signed'({~quo[7], quo[6:0]});

  always_ff @(posedge clk) begin
    if (en.s2) begin
      joy_r <= joy_nxt;
    end
  end

  assign joy = joy_r;

endmodule

`default_nettype wire

### rtl/jddm_mix.sv
// Premix, pivot weighting and blended mix for both motors (two stages).
`default_nettype none

module jddm_mix
  import jddm_pkg::*;
(
  input  wire logic      clk,
  input  var  stage_en_t en,
  input  wire joy_t      jx,
  input  wire joy_t      jy,
  output mix_t           mix_l,
  output mix_t           mix_r
);

  premix_t drv_a;
  premix_t drv_b;
  premix_t full;
  premix_t pl_nxt;
  premix_t pr_nxt;
  logic    jx_neg;
  logic    jy_neg;
  logic [7:0] jy_mag;
  logic [5:0] w;
  logic [5:0] pw;
  logic signed [14:0] wjy_full;
  logic signed [14:0] piv_full;

  premix_t pl_r;
  premix_t pr_r;
  term_t   wjy_r;
  term_t   piv_r;

  logic signed [22:0] prod_l;
  logic signed [22:0] prod_r;
  logic signed [23:0] piv_sh;
  logic signed [23:0] num_l;
  logic signed [23:0] num_r;
  logic signed [23:0] rnd_l;
  logic signed [23:0] rnd_r;
  mix_t mix_l_r;
  mix_t mix_r_r;

  assign jx_neg = jx[7];
  assign jy_neg = jy[7];
  assign full   = 9'sd127;
  assign drv_a  = full - 9'(jx);
  assign drv_b  = full + 9'(jx);

  always_comb begin
    if (!jy_neg) begin
      pl_nxt = jx_neg ? drv_b : full;
      pr_nxt = jx_neg ? full  : drv_a;
    end else begin
      pl_nxt = jx_neg ? full  : drv_a;
      pr_nxt = jx_neg ? drv_b : full;
    end
  end

  assign jy_mag   = jy_neg ? (~jy + 8'd1) : jy;
  assign w        = (jy_mag > 8'd32) ? 6'd32 : jy_mag[5:0];
  assign pw       = 6'd32 - w;
  assign wjy_full = 15'(signed'({1'b0, w})) * 15'(jy);
  assign piv_full = 15'(signed'({1'b0, pw})) * 15'(jx);

  always_ff @(posedge clk) begin
    if (en.s3) begin
      pl_r  <= pl_nxt;
      pr_r  <= pr_nxt;
      wjy_r <= signed'(wjy_full[13:0]);
      piv_r <= signed'(piv_full[13:0]);
    end
  end

  // /4096 truncating toward zero
  assign prod_l = 23'(wjy_r) * 23'(pl_r);
  assign prod_r = 23'(wjy_r) * 23'(pr_r);
  assign piv_sh = 24'(piv_r) <<< 7;
  assign num_l  = 24'(prod_l) + piv_sh;
  assign num_r  = 24'(prod_r) - piv_sh;
  assign rnd_l  = num_l[23] ? (num_l + 24'sd4095) : num_l;
  assign rnd_r  = num_r[23] ? (num_r + 24'sd4095) : num_r;

  always_ff @(posedge clk) begin
    if (en.s4) begin
      mix_l_r <= signed'(rnd_l[21:12]);
      mix_r_r <= signed'(rnd_r[21:12]);
    end
  end

  assign mix_l = mix_l_r;
  assign mix_r = mix_r_r;

endmodule

`default_nettype wire

### rtl/jddm_drive.sv
// Bridge direction levels and saturated duty for one motor (output stage).
`default_nettype none

module jddm_drive
  import jddm_pkg::*;
(
  input  wire logic      clk,
  input  var  stage_en_t en,
  input  wire mix_t      mix,
  output logic           fwd_pin,
  output logic           rev_pin,
  output duty_t          duty
);

  logic [9:0] mag;
  duty_t      duty_nxt;
  logic       fwd_r;
  logic       rev_r;
  duty_t      duty_r;

  assign mag = mix[9] ? (~mix + 10'd1) : mix;

  // mag*255/127 = 2*mag + mag/127; anything from 128 up saturates
  assign duty_nxt = (mag >= 10'd128) ? 8'd255
                  : ({mag[6:0], 1'b0} + {7'd0, (mag == 10'd127)});

  always_ff @(posedge clk) begin
    if (en.s5) begin
      fwd_r  <= ~mix[9];
      rev_r  <= mix[9];
      duty_r <= duty_nxt;
    end
  end

  assign fwd_pin = fwd_r;
  assign rev_pin = rev_r;
  assign duty    = duty_r;

endmodule

`default_nettype wire

### rtl/joystick_differential_drive_mixer_unit.sv
// An accepted input word passes through 5 register stages on its way to out_tvalid.
// Throughput: one word per cycle while out_tready is high; each stage holds a word and
// accepts a new one whenever it is empty or its downstream stage moves, so bubbles collapse.
// The deepest stage is the wJY*premix multiply plus the blend add.
// Reset (rst_n low, synchronous): all stage valid bits cleared, dead_band = 30,
// center_value = 511. Data registers are not reset.
`default_nettype none

module joystick_differential_drive_mixer_unit
  import jddm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [9:0] x_position, [19:10] y_position, zero pad
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [0] left_fwd_pin, [1] left_rev_pin,
                                       // [9:2] left_duty, [10] right_fwd_pin,
                                       // [11] right_rev_pin, [19:12] right_duty, zero pad
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire cfg_idx_t    cfg_index,
  input  wire logic [9:0]  cfg_data
);

  // ---------------------------------------------------------------------------
  // Config registers. Writes must arrive only while the pipe is empty (the block does
  // not enforce this), so stage 1 reads them directly.
  // ---------------------------------------------------------------------------
  band_t dead_band_r;
  axis_t center_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dead_band_r    <= DEAD_BAND_RST;
      center_value_r <= CENTER_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_IDX_DEAD_BAND: dead_band_r    <= cfg_data[8:0];
        CFG_IDX_CENTER:    center_value_r <= cfg_data;
        default:           ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: a valid bit per stage, per-stage ready so a stall only
  // backs up as far as it has to.
  // ---------------------------------------------------------------------------
  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] vld_nxt;
  logic [NUM_STAGES-1:0] rdy;
  logic [NUM_STAGES-1:0] vld_up;
  stage_en_t             en;

  always_comb begin
    rdy[NUM_STAGES-1] = ~vld_r[NUM_STAGES-1] | out_tready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      rdy[k] = ~vld_r[k] | rdy[k+1];
    end
  end

  assign vld_up  = {vld_r[NUM_STAGES-2:0], in_tvalid};
  assign vld_nxt = (rdy & vld_up) | (~rdy & vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign en = '{s1: rdy[0], s2: rdy[1], s3: rdy[2], s4: rdy[3], s5: rdy[4]};

  assign in_tready  = rdy[0];
  assign out_tvalid = vld_r[NUM_STAGES-1];

  // ---------------------------------------------------------------------------
  // Datapath
  //   stages 1-2: per-axis dead band and 0..1023 -> -128..127 mapping
  //   stages 3-4: premix / pivot weight, then blend and /4096
  //   stage 5   : direction levels and duty
  // ---------------------------------------------------------------------------
  joy_t  jx;
  joy_t  jy;
  mix_t  mix_l;
  mix_t  mix_r;
  logic  left_fwd_pin;
  logic  left_rev_pin;
  duty_t left_duty;
  logic  right_fwd_pin;
  logic  right_rev_pin;
  duty_t right_duty;

  jddm_axis u_axis_x (
    .clk          (clk),
    .en           (en),
    .dead_band    (dead_band_r),
    .center_value (center_value_r),
    .raw          (in_tdata[9:0]),
    .joy          (jx)
  );

  jddm_axis u_axis_y (
    .clk          (clk),
    .en           (en),
    .dead_band    (dead_band_r),
    .center_value (center_value_r),
    .raw          (in_tdata[19:10]),
    .joy          (jy)
  );

  jddm_mix u_mix (
    .clk   (clk),
    .en    (en),
    .jx    (jx),
    .jy    (jy),
    .mix_l (mix_l),
    .mix_r (mix_r)
  );

  jddm_drive u_drive_l (
    .clk     (clk),
    .en      (en),
    .mix     (mix_l),
    .fwd_pin (left_fwd_pin),
    .rev_pin (left_rev_pin),
    .duty    (left_duty)
  );

  jddm_drive u_drive_r (
    .clk     (clk),
    .en      (en),
    .mix     (mix_r),
    .fwd_pin (right_fwd_pin),
    .rev_pin (right_rev_pin),
    .duty    (right_duty)
  );

  assign out_tdata = {4'd0, right_duty, right_rev_pin, right_fwd_pin,
                      left_duty, left_rev_pin, left_fwd_pin};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // A full pipe with a stalled output must not take a new word.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    ((&vld_r) && !out_tready) |-> !in_tready)
    else $error("input accepted while pipe full and output stalled");

  // An accepted word always lands in stage 1.
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> vld_r[0])
    else $error("accepted word lost at stage 1");

  // Direction levels of a shown word are complementary.
  a_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((left_fwd_pin != left_rev_pin) && (right_fwd_pin != right_rev_pin)))
    else $error("bridge direction levels not complementary");

endmodule

`default_nettype wire

### tb/drive_mix_checker.sv
// Checker for the drive mixer: predicts every result word and compares it field by field.
module drive_mix_checker
  import jddm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,    // [9:0] x_position, [19:10] y_position, zero pad
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,   // [0] left_fwd_pin, [1] left_rev_pin, [9:2] left_duty,
                                   // [10] right_fwd_pin, [11] right_rev_pin,
                                   // [19:12] right_duty, zero pad
  input  logic        cfg_wr_en,
  input  cfg_idx_t    cfg_index,
  input  logic [9:0]  cfg_data,
  output int          mismatches,
  output int          words_in_flight
);
  timeunit 1ns;
  timeprecision 1ps;

  // Result word, LSB field last
  typedef struct packed {
    logic [3:0] pad;
    duty_t      right_duty;
    logic       right_rev_pin;
    logic       right_fwd_pin;
    duty_t      left_duty;
    logic       left_rev_pin;
    logic       left_fwd_pin;
  } drive_word_t;

  typedef struct packed {
    logic  fwd;
    logic  rev;
    duty_t duty;
  } bridge_cmd_t;

  band_t       band_q;
  axis_t       center_q;
  drive_word_t expected_drive[$];

  // Dead band (limits unclipped), then v*255/1023 - 128
  function automatic joy_t map_axis(axis_t raw);
    int v, c, t;
    v = raw;
    c = center_q;
    t = band_q;
    if (v >= c - t && v <= c + t) v = c;
    return joy_t'((v * 255) / 1023 - 128);
  endfunction

  function automatic bridge_cmd_t bridge_from_mix(int mix);
    bridge_cmd_t cmd;
    int mag, d;
    mag = (mix < 0) ? -mix : mix;
    d = (mag * 255) / 127;
    if (d > 255) d = 255;
    cmd.fwd  = (mix >= 0);
    cmd.rev  = (mix < 0);
    cmd.duty = duty_t'(d);
    return cmd;
  endfunction

  function automatic drive_word_t predict_drive(axis_t x, axis_t y);
    drive_word_t word;
    bridge_cmd_t lc, rc;
    int jx, jy, pl, pr, wt, mix_l, mix_r;
    jx = map_axis(x);
    jy = map_axis(y);
    if (jy >= 0) begin
      pl = (jx >= 0) ? 127 : 127 + jx;
      pr = (jx >= 0) ? 127 - jx : 127;
    end else begin
      pl = (jx >= 0) ? 127 - jx : 127;
      pr = (jx >= 0) ? 127 : 127 + jx;
    end
    wt = (jy < 0) ? -jy : jy;
    if (wt > 32) wt = 32;
    // SV int division truncates toward zero
    mix_l = (wt * pl * jy + (32 - wt) * 128 * jx) / 4096;
    mix_r = (wt * pr * jy - (32 - wt) * 128 * jx) / 4096;
    lc = bridge_from_mix(mix_l);
    rc = bridge_from_mix(mix_r);
    word = '0;
    word.left_fwd_pin  = lc.fwd;
    word.left_rev_pin  = lc.rev;
    word.left_duty     = lc.duty;
    word.right_fwd_pin = rc.fwd;
    word.right_rev_pin = rc.rev;
    word.right_duty    = rc.duty;
    return word;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    drive_word_t got, want;
    if (!rst_n) begin
      band_q     = DEAD_BAND_RST;
      center_q   = CENTER_RST;
      mismatches = 0;
      expected_drive.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_IDX_DEAD_BAND: band_q = cfg_data[8:0];
          CFG_IDX_CENTER:    center_q = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        expected_drive.push_back(predict_drive(in_tdata[9:0], in_tdata[19:10]));
      if (out_tvalid && out_tready) begin
        got = drive_word_t'(out_tdata);
        if (expected_drive.size() == 0) begin
          $error("result word with no expectation: %h", out_tdata);
          mismatches++;
        end else begin
          want = expected_drive.pop_front();
          check_field("left_fwd_pin",  want.left_fwd_pin,  got.left_fwd_pin);
          check_field("left_rev_pin",  want.left_rev_pin,  got.left_rev_pin);
          check_field("left_duty",     want.left_duty,     got.left_duty);
          check_field("right_fwd_pin", want.right_fwd_pin, got.right_fwd_pin);
          check_field("right_rev_pin", want.right_rev_pin, got.right_rev_pin);
          check_field("right_duty",    want.right_duty,    got.right_duty);
        end
      end
    end
    words_in_flight = expected_drive.size();
  end

endmodule

### tb/tb.sv
// Top of the drive mixer testbench: clock, reset, stimulus, config phases and verdict.
module tb
  import jddm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_PHASES      = 9;
  localparam int WORDS_PER_PHASE = 170;
  localparam int CYCLE_LIMIT     = 1_000_000;
  // Indexes with no register behind them; writes must be dropped
  localparam cfg_idx_t CFG_IDX_UNUSED_2 = 2'd2;
  localparam cfg_idx_t CFG_IDX_UNUSED_3 = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // [9:0] x_position, [19:10] y_position, zero pad
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // [0] left_fwd_pin, [1] left_rev_pin, [9:2] left_duty,
                                // [10] right_fwd_pin, [11] right_rev_pin,
                                // [19:12] right_duty, zero pad
  logic        cfg_wr_en = 1'b0;
  cfg_idx_t    cfg_index = CFG_IDX_DEAD_BAND;
  logic [9:0]  cfg_data = '0;

  int mismatches;
  int words_in_flight;
  int cycle_count = 0;
  int stall_left = 0;
  bit quiet_run = 1'b0;     // no new gaps start on either side while set

  // Stimulus-side copy of the config, only used to aim samples at band edges and near center
  int band_now = DEAD_BAND_RST;
  int center_now = CENTER_RST;

  joystick_differential_drive_mixer_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  drive_mix_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .words_in_flight (words_in_flight)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Result-side backpressure, changed on the falling edge
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet_run && $urandom_range(0, 99) < 30) begin
      out_tready <= 1'b0;
      stall_left <= gap_len() - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Random axis sample: extremes, both dead band edges, near center, or anywhere
  function automatic axis_t pick_axis();
    int v;
    case ($urandom_range(0, 9))
      0: v = $urandom_range(0, 1) ? 1023 : 0;
      1: v = center_now - band_now + int'($urandom_range(0, 2)) - 1;
      2: v = center_now + band_now + int'($urandom_range(0, 2)) - 1;
      3: v = center_now + int'($urandom_range(0, 80)) - 40;
      default: v = $urandom_range(0, 1023);
    endcase
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return axis_t'(v);
  endfunction

  // Present one sample word and hold it until the handshake; valid is lowered
  // only while a gap is inserted, so it never drops between back-to-back words
  task automatic send_word(axis_t x, axis_t y);
    int gap;
    gap = (quiet_run || $urandom_range(0, 1)) ? 0 : gap_len();
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [9:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Stop sending and wait until every result word is back
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (words_in_flight != 0) @(negedge clk);
    repeat (NUM_STAGES + 2) @(negedge clk);
  endtask

  // Raw register data per phase; dead band data may carry bit 9 to check masking
  task automatic phase_setting(int p, output logic [9:0] band_raw,
                               output logic [9:0] center_raw);
    case (p)
      1: begin band_raw = 10'd30;  center_raw = 10'd514;  end // throttle centered at jy=0
      2: begin band_raw = 10'd0;   center_raw = 10'd0;    end
      3: begin band_raw = 10'd511; center_raw = 10'd1023; end // band covers the upper half
      4: begin band_raw = 10'd511; center_raw = 10'd0;    end // band reaches below 0
      5: begin band_raw = 10'd300; center_raw = 10'd1023; end // band reaches above 1023
      6: begin band_raw = 10'd0;   center_raw = 10'd1023; end
      7: begin band_raw = 10'h211; center_raw = 10'd300;  end
      default: begin
        band_raw   = 10'($urandom_range(0, 1023));
        center_raw = 10'($urandom_range(0, 1023));
      end
    endcase
  endtask

  initial begin
    logic [9:0] band_raw, center_raw;
    // Synchronous reset
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < NUM_PHASES; p++) begin
      // Phase 0 runs on reset values of the registers
      if (p > 0) begin
        settle();
        phase_setting(p, band_raw, center_raw);
        write_reg(CFG_IDX_DEAD_BAND, band_raw);
        write_reg(CFG_IDX_CENTER, center_raw);
        if (p % 3 == 1) begin
          write_reg(CFG_IDX_UNUSED_2, 10'($urandom_range(0, 1023)));
          write_reg(CFG_IDX_UNUSED_3, 10'($urandom_range(0, 1023)));
        end
        band_now   = band_raw[8:0];
        center_now = center_raw;
      end

      if (p == 0) begin
        // corners and center
        send_word(10'd0,    10'd0);
        send_word(10'd1023, 10'd1023);
        send_word(10'd0,    10'd1023);
        send_word(10'd1023, 10'd0);
        send_word(10'd511,  10'd511);
        // X dead band edges, in and just out
        send_word(10'd481,  10'd511);
        send_word(10'd480,  10'd511);
        send_word(10'd541,  10'd511);
        send_word(10'd542,  10'd511);
        // Y dead band edges
        send_word(10'd511,  10'd481);
        send_word(10'd511,  10'd480);
        send_word(10'd511,  10'd541);
        send_word(10'd511,  10'd542);
        // pivot at little throttle
        send_word(10'd1023, 10'd511);
        send_word(10'd0,    10'd511);
        // throttle around the end of the pivot blend, both directions
        send_word(10'd700,  10'd642);
        send_word(10'd300,  10'd642);
        send_word(10'd700,  10'd380);
        send_word(10'd300,  10'd380);
        // alternating bit patterns
        send_word(10'h2AA,  10'h155);
        send_word(10'h155,  10'h2AA);
      end
      if (p == 1) begin
        // Zero throttle: full-left pivot saturates the duty, full-right hits 255 exactly
        send_word(10'd0,    10'd514);
        send_word(10'd0,    10'd544);
        send_word(10'd1023, 10'd514);
      end

      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if (n % 64 == 0) quiet_run = ($urandom_range(0, 3) == 0);
        send_word(pick_axis(), pick_axis());
      end
    end

    settle();
    repeat (2 * NUM_STAGES) @(negedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
